// File: rtl/flash_sector_remap_allocator_defines.svh
// Assertion macros used by the checker file of the sector remap allocator.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef FLASH_SECTOR_REMAP_ALLOCATOR_DEFINES_SVH
`define FLASH_SECTOR_REMAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FSRA_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define FSRA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// File: rtl/fsra_pkg.sv
// Shared types and constants of the flash sector remap allocator.
// No dependencies; imported by the top, fsra_ctrl, fsra_dp and fsra_checker.
package fsra_pkg;

  // Geometry of the flash and of the logical space.
  localparam int PHYS_SECTORS     = 4096;
  localparam int LOGICAL_SECTORS  = 30716;
  localparam int RESERVED_SECTORS = 15;
  localparam int FIRST_MAP_SPAN   = 2044;
  localparam int MAP_SPAN         = 2048;
  localparam int MAP_SPAN_SHIFT   = $clog2(MAP_SPAN);

  // Storage address widths.
  localparam int PHYS_AW = $clog2(PHYS_SECTORS);
  localparam int MAP_AW  = $clog2(LOGICAL_SECTORS);
  localparam int CLR_LEN = (LOGICAL_SECTORS > PHYS_SECTORS) ? LOGICAL_SECTORS : PHYS_SECTORS;
  localparam int CLR_W   = $clog2(CLR_LEN);

  // Field widths.
  localparam int LSEC_W   = 15;
  localparam int ENTRY_W  = 16;
  localparam int STATUS_W = 2;
  localparam int SEC_W    = 13;
  localparam int PAGE_W   = 3;
  localparam int ERASE_W  = 2;
  localparam int MASK_W   = 8;
  localparam int MPAGE_W  = 4;
  localparam int DIRTY_W  = 15;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_LOAD  = 2'd2,
    MODE_SYNC  = 2'd3
  } mode_e;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNMAPPED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

  localparam logic [ERASE_W-1:0] ERASE_NONE  = 2'd0;
  localparam logic [ERASE_W-1:0] ERASE_PLAIN = 2'd1;
  localparam logic [ERASE_W-1:0] ERASE_KEEP  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic accept;
    logic decode;
    logic map_chk;
    logic old_wr;
    logic scan;
    logic commit;
    logic new_wr;
    logic done;
  } fsra_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic  clear_done;
    mode_e mode;
    logic  in_range;
    logic  load_used;
    logic  need_free;
    logic  need_scan;
    logic  scan_hit;
    logic  scan_full;
    logic  out_free;
  } fsra_stat_t;

endpackage

// File: rtl/flash_sector_remap_allocator.sv
// Top level of the flash sector remap allocator.
// Depends on fsra_pkg, fsra_ctrl and fsra_dp.
//
// Maps logical 512-byte sectors to pages of 8-page physical sectors and
// allocates pages for writes. After reset the block clears its map table and
// used-page bitmap, with in_ready_o low. One transaction is worked on at a
// time; when a write finds no open sector with a free page, a new sector is
// found by a bitmap scan, one bitmap memory read per cycle from the rotating
// search start. The result sits in an output register, so the next
// transaction is taken while it waits.
module flash_sector_remap_allocator import fsra_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          mode_i,
  input  logic [LSEC_W-1:0]   logical_sector_i,
  input  logic [ENTRY_W-1:0]  entry_value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [SEC_W-1:0]    phys_sector_o,
  output logic [PAGE_W-1:0]   page_offset_o,
  output logic [ERASE_W-1:0]  erase_action_o,
  output logic [MASK_W-1:0]   keep_mask_o,
  output logic [MPAGE_W-1:0]  map_page_o,
  output logic [DIRTY_W-1:0]  dirty_pages_o
);

  fsra_cmd_t  cmd;
  fsra_stat_t stat;

  fsra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fsra_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .mode_i           (mode_i),
    .logical_sector_i (logical_sector_i),
    .entry_value_i    (entry_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .phys_sector_o    (phys_sector_o),
    .page_offset_o    (page_offset_o),
    .erase_action_o   (erase_action_o),
    .keep_mask_o      (keep_mask_o),
    .map_page_o       (map_page_o),
    .dirty_pages_o    (dirty_pages_o)
  );

endmodule

// File: rtl/fsra_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module fsra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/fsra_ctrl.sv
// Sequencing state machine of the sector remap allocator.
// Depends on fsra_pkg; drives the datapath through fsra_cmd_t.
module fsra_ctrl import fsra_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  fsra_stat_t stat_i,
  output fsra_cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    S_CLEAR   = 9'b000000001,
    S_IDLE    = 9'b000000010,
    S_DECODE  = 9'b000000100,
    S_MAP_CHK = 9'b000001000,
    S_OLD_WR  = 9'b000010000,
    S_SCAN    = 9'b000100000,
    S_COMMIT  = 9'b001000000,
    S_NEW_WR  = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        unique case (stat_i.mode)
          MODE_READ, MODE_WRITE: state_d = stat_i.in_range ? S_MAP_CHK : S_DONE;
          MODE_LOAD: state_d = (stat_i.in_range && stat_i.load_used) ? S_NEW_WR : S_DONE;
          default: state_d = S_DONE;
        endcase
      end
      S_MAP_CHK: begin
        cmd_o.map_chk = 1'b1;
        if (stat_i.mode == MODE_READ) state_d = S_DONE;
        else if (stat_i.need_free) state_d = S_OLD_WR;
        else if (stat_i.need_scan) state_d = S_SCAN;
        else state_d = S_COMMIT;
      end
      S_OLD_WR: begin
        cmd_o.old_wr = 1'b1;
        state_d = stat_i.need_scan ? S_SCAN : S_COMMIT;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_hit) state_d = S_COMMIT;
        else if (stat_i.scan_full) state_d = S_DONE;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d = S_NEW_WR;
      end
      S_NEW_WR: begin
        cmd_o.new_wr = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        cmd_o.done = stat_i.out_free;
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// File: rtl/fsra_dp.sv
// Datapath of the sector remap allocator: map table, used-page bitmap,
// open sector, search pointer, dirty flags and result register.
// Depends on fsra_pkg and fsra_ram; steered by fsra_ctrl.
module fsra_dp import fsra_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fsra_cmd_t           cmd_i,
  output fsra_stat_t          stat_o,
  input  logic [1:0]          mode_i,
  input  logic [LSEC_W-1:0]   logical_sector_i,
  input  logic [ENTRY_W-1:0]  entry_value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [SEC_W-1:0]    phys_sector_o,
  output logic [PAGE_W-1:0]   page_offset_o,
  output logic [ERASE_W-1:0]  erase_action_o,
  output logic [MASK_W-1:0]   keep_mask_o,
  output logic [MPAGE_W-1:0]  map_page_o,
  output logic [DIRTY_W-1:0]  dirty_pages_o
);

  // Lowest free page of a mask; page 7 when no lower page is free.
  function automatic logic [PAGE_W-1:0] low_page(input logic [MASK_W-1:0] m);
    logic [PAGE_W-1:0] p;
    p = PAGE_W'(MASK_W - 1);
    for (int i = MASK_W - 2; i >= 0; i--) begin
      if (m[i]) p = PAGE_W'(i);
    end
    return p;
  endfunction

  // Latched request.
  mode_e               mode_q;
  logic [LSEC_W-1:0]   ls_q;
  logic [ENTRY_W-1:0]  ev_q;

  // Control registers.
  logic [CLR_W-1:0]    clr_cnt_q, clr_cnt_d;
  logic [SEC_W-1:0]    open_sec_q, open_sec_d;
  logic [MASK_W-1:0]   open_mask_q, open_mask_d;
  logic [PHYS_AW-1:0]  search_q, search_d;
  logic [DIRTY_W-1:0]  dirty_q, dirty_d;
  logic                out_valid_q, out_valid_d;
  logic [PHYS_AW:0]    scan_cnt_q;
  logic                pend_q;
  logic                part_found_q;

  // Payload registers.
  logic [SEC_W-1:0]    old_sec_q, tgt_sec_q;
  logic [PAGE_W-1:0]   old_pg_q, tgt_pg_q;
  logic [PHYS_AW-1:0]  pidx_q, part_idx_q;
  logic [MASK_W-1:0]   part_keep_q;
  logic [STATUS_W-1:0] res_status_q;
  logic [SEC_W-1:0]    res_phys_q;
  logic [PAGE_W-1:0]   res_page_q;
  logic [ERASE_W-1:0]  res_erase_q;
  logic [MASK_W-1:0]   res_keep_q;
  logic [MPAGE_W-1:0]  res_mpage_q;
  logic [DIRTY_W-1:0]  res_dirty_q;

  // Memory ports.
  logic                map_we, map_re;
  logic [MAP_AW-1:0]   map_waddr;
  logic [ENTRY_W-1:0]  map_wdata, map_rdata;
  logic                used_we, used_re;
  logic [PHYS_AW-1:0]  used_waddr, used_raddr;
  logic [MASK_W-1:0]   used_wdata, used_rdata;

  // Derived values.
  logic                in_range;
  logic [PAGE_W-1:0]   new_pg;
  logic [ENTRY_W-1:0]  ls_off;
  logic [MPAGE_W-1:0]  mpage;
  logic [PHYS_AW:0]    scan_sum;
  logic [PHYS_AW-1:0]  scan_addr;
  logic                scan_issue, scan_free, scan_end;

  assign in_range = 32'(ls_q) < LOGICAL_SECTORS;
  assign new_pg   = low_page(open_mask_q);
  // Map page: first span is short, the rest are MAP_SPAN sectors each.
  assign ls_off   = ENTRY_W'(ls_q) + ENTRY_W'(MAP_SPAN - FIRST_MAP_SPAN);
  assign mpage    = MPAGE_W'(ls_off >> MAP_SPAN_SHIFT);

  // Scan address wraps around the physical sector range.
  assign scan_sum   = {1'b0, search_q} + {1'b0, scan_cnt_q[PHYS_AW-1:0]};
  assign scan_addr  = (32'(scan_sum) >= PHYS_SECTORS)
                    ? PHYS_AW'(scan_sum - (PHYS_AW+1)'(PHYS_SECTORS))
                    : scan_sum[PHYS_AW-1:0];
  assign scan_issue = cmd_i.scan && (32'(scan_cnt_q) < PHYS_SECTORS);
  assign scan_free  = cmd_i.scan && pend_q && (used_rdata == '0);
  assign scan_end   = cmd_i.scan && !pend_q && (32'(scan_cnt_q) == PHYS_SECTORS);

  // Status toward the controller.
  always_comb begin
    stat_o.clear_done = (32'(clr_cnt_q) == CLR_LEN - 1);
    stat_o.mode       = mode_q;
    stat_o.in_range   = in_range;
    stat_o.load_used  = (ev_q != '0) && (32'(ev_q[ENTRY_W-1:PAGE_W]) < PHYS_SECTORS);
    stat_o.need_free  = (map_rdata != '0)
                     && (32'(map_rdata[ENTRY_W-1:PAGE_W]) < PHYS_SECTORS);
    stat_o.need_scan  = (open_sec_q == '0) || (open_mask_q == '0);
    stat_o.scan_hit   = scan_free || (scan_end && part_found_q);
    stat_o.scan_full  = scan_end && !part_found_q;
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  // Map table ports.
  always_comb begin
    map_re    = cmd_i.decode && in_range;
    map_we    = 1'b0;
    map_waddr = ls_q[MAP_AW-1:0];
    map_wdata = ev_q;
    if (cmd_i.clear) begin
      map_we    = 32'(clr_cnt_q) < LOGICAL_SECTORS;
      map_waddr = clr_cnt_q[MAP_AW-1:0];
      map_wdata = '0;
    end else if (cmd_i.decode) begin
      map_we    = (mode_q == MODE_LOAD) && in_range;
    end else if (cmd_i.commit) begin
      map_we    = 1'b1;
      map_wdata = {open_sec_q, new_pg};
    end
  end

  // Used-page bitmap read port.
  always_comb begin
    used_re    = 1'b0;
    used_raddr = scan_addr;
    if (cmd_i.decode) begin
      used_re    = 1'b1;
      used_raddr = ev_q[PHYS_AW+PAGE_W-1:PAGE_W];
    end else if (cmd_i.map_chk) begin
      used_re    = 1'b1;
      used_raddr = map_rdata[PHYS_AW+PAGE_W-1:PAGE_W];
    end else if (cmd_i.scan) begin
      used_re    = scan_issue;
    end else if (cmd_i.commit) begin
      used_re    = 1'b1;
      used_raddr = open_sec_q[PHYS_AW-1:0];
    end
  end

  // Used-page bitmap write port: clearing pass, page free, page take.
  always_comb begin
    used_we    = 1'b0;
    used_waddr = tgt_sec_q[PHYS_AW-1:0];
    used_wdata = used_rdata | (MASK_W'(1) << tgt_pg_q);
    if (cmd_i.clear) begin
      used_we    = 32'(clr_cnt_q) < PHYS_SECTORS;
      used_waddr = clr_cnt_q[PHYS_AW-1:0];
      used_wdata = (32'(clr_cnt_q) < RESERVED_SECTORS) ? '1 : '0;
    end else if (cmd_i.old_wr) begin
      used_we    = 1'b1;
      used_waddr = old_sec_q[PHYS_AW-1:0];
      used_wdata = used_rdata & ~(MASK_W'(1) << old_pg_q);
    end else if (cmd_i.new_wr) begin
      used_we    = 1'b1;
    end
  end

  fsra_ram #(.WIDTH(ENTRY_W), .DEPTH(LOGICAL_SECTORS)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (ls_q[MAP_AW-1:0]),
    .rdata_o (map_rdata)
  );

  fsra_ram #(.WIDTH(MASK_W), .DEPTH(PHYS_SECTORS)) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (used_we),
    .waddr_i (used_waddr),
    .wdata_i (used_wdata),
    .re_i    (used_re),
    .raddr_i (used_raddr),
    .rdata_o (used_rdata)
  );

  // Next values of the allocation and bookkeeping state.
  always_comb begin
    clr_cnt_d   = cmd_i.clear ? clr_cnt_q + CLR_W'(1) : clr_cnt_q;
    open_sec_d  = open_sec_q;
    open_mask_d = open_mask_q;
    search_d    = search_q;
    dirty_d     = dirty_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_i.done) out_valid_d = 1'b1;
    if (cmd_i.decode && mode_q == MODE_LOAD && in_range) open_sec_d = '0;
    if (cmd_i.decode && mode_q == MODE_SYNC) dirty_d = '0;
    if (scan_free) begin
      open_sec_d  = SEC_W'(pidx_q);
      open_mask_d = '1;
      search_d    = pidx_q;
    end else if (scan_end && part_found_q) begin
      open_sec_d  = SEC_W'(part_idx_q);
      open_mask_d = ~part_keep_q;
      search_d    = part_idx_q;
    end
    if (cmd_i.commit) begin
      open_mask_d = open_mask_q & ~(MASK_W'(1) << new_pg);
      dirty_d     = dirty_q | (DIRTY_W'(1) << mpage);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      open_sec_q  <= '0;
      open_mask_q <= '0;
      search_q    <= '0;
      dirty_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      clr_cnt_q   <= clr_cnt_d;
      open_sec_q  <= open_sec_d;
      open_mask_q <= open_mask_d;
      search_q    <= search_d;
      dirty_q     <= dirty_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Scan pipeline: one bitmap read issued per cycle, its data checked in the cycle after.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_cnt_q   <= '0;
      pend_q       <= 1'b0;
      part_found_q <= 1'b0;
    end else if (!cmd_i.scan) begin
      scan_cnt_q   <= '0;
      pend_q       <= 1'b0;
      part_found_q <= 1'b0;
    end else begin
      if (scan_issue) scan_cnt_q <= scan_cnt_q + (PHYS_AW+1)'(1);
      pend_q <= scan_issue;
      if (pend_q && used_rdata != '0 && used_rdata != '1 && !part_found_q) begin
        part_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_issue) pidx_q <= scan_addr;
    if (cmd_i.scan && pend_q && used_rdata != '0 && used_rdata != '1 && !part_found_q) begin
      part_idx_q  <= pidx_q;
      part_keep_q <= used_rdata;
    end
  end

  // Request capture and result building.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q <= mode_e'(mode_i);
      ls_q   <= logical_sector_i;
      ev_q   <= entry_value_i;
    end
    if (cmd_i.decode) begin
      // Out-of-range reads and writes answer as unmapped.
      res_status_q <= ((mode_q == MODE_READ || mode_q == MODE_WRITE) && !in_range)
                    ? ST_UNMAPPED : ST_OK;
      res_phys_q   <= '0;
      res_page_q   <= '0;
      res_erase_q  <= ERASE_NONE;
      res_keep_q   <= '0;
      res_mpage_q  <= '0;
      res_dirty_q  <= (mode_q == MODE_SYNC) ? dirty_q : '0;
      tgt_sec_q    <= ev_q[ENTRY_W-1:PAGE_W];
      tgt_pg_q     <= ev_q[PAGE_W-1:0];
    end
    if (cmd_i.map_chk) begin
      old_sec_q <= map_rdata[ENTRY_W-1:PAGE_W];
      old_pg_q  <= map_rdata[PAGE_W-1:0];
      if (mode_q == MODE_READ) begin
        if (map_rdata == '0) begin
          res_status_q <= ST_UNMAPPED;
        end else begin
          res_phys_q <= map_rdata[ENTRY_W-1:PAGE_W];
          res_page_q <= map_rdata[PAGE_W-1:0];
        end
      end
    end
    if (scan_free) begin
      res_erase_q <= ERASE_PLAIN;
    end else if (scan_end && part_found_q) begin
      res_erase_q <= ERASE_KEEP;
      res_keep_q  <= part_keep_q;
    end else if (scan_end) begin
      res_status_q <= ST_FULL;
    end
    if (cmd_i.commit) begin
      res_phys_q  <= open_sec_q;
      res_page_q  <= new_pg;
      res_mpage_q <= mpage;
      tgt_sec_q   <= open_sec_q;
      tgt_pg_q    <= new_pg;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.done) begin
      status_o       <= res_status_q;
      phys_sector_o  <= res_phys_q;
      page_offset_o  <= res_page_q;
      erase_action_o <= res_erase_q;
      keep_mask_o    <= res_keep_q;
      map_page_o     <= res_mpage_q;
      dirty_pages_o  <= res_dirty_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/fsra_checker.sv
// Port-level assertions of the flash sector remap allocator, bound to the top.
// Depends on fsra_pkg and flash_sector_remap_allocator_defines.svh.
`include "flash_sector_remap_allocator_defines.svh"

module fsra_checker import fsra_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [STATUS_W-1:0] status_o,
  input logic [SEC_W-1:0]    phys_sector_o,
  input logic [PAGE_W-1:0]   page_offset_o,
  input logic [ERASE_W-1:0]  erase_action_o,
  input logic [MASK_W-1:0]   keep_mask_o,
  input logic [MPAGE_W-1:0]  map_page_o,
  input logic [DIRTY_W-1:0]  dirty_pages_o
);

  // A stalled result transaction holds.
  `FSRA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(phys_sector_o) && $stable(page_offset_o))

  // A full flash reports nothing but its status.
  `FSRA_ASSERT_IMPLY(a_full_clean, out_valid_o && status_o == ST_FULL, phys_sector_o == '0 && page_offset_o == '0 && erase_action_o == ERASE_NONE && keep_mask_o == '0 && map_page_o == '0)

  // A keep mask only comes with an erase that keeps pages.
  `FSRA_ASSERT_IMPLY(a_keep_only_copy, out_valid_o && erase_action_o != ERASE_KEEP, keep_mask_o == '0)

  // Dirty flags are reported only by a sync, which touches nothing else.
  `FSRA_ASSERT_IMPLY(a_sync_clean, out_valid_o && dirty_pages_o != '0, status_o == ST_OK && erase_action_o == ERASE_NONE && map_page_o == '0 && phys_sector_o == '0)

endmodule

bind flash_sector_remap_allocator fsra_checker u_fsra_checker (.*);
